// ===== sv/rgbhsv_pkg.sv =====
// Shared types, widths and constants of the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int COLOR_BITS    = 8;
  localparam int HUE_FRAC_BITS = 6;

  // Hue spans 0 to below 360 degrees: nine integer bits plus the fraction.
  localparam int HUE_W    = 9 + HUE_FRAC_BITS;
  // Hue factor: up to six sectors times delta.
  localparam int FACTOR_W = COLOR_BITS + 3;
  localparam int HNUM_W   = HUE_W + COLOR_BITS;
  localparam int SNUM_W   = 2 * COLOR_BITS;

  localparam int DIV_STEPS = (HUE_W > COLOR_BITS) ? HUE_W : COLOR_BITS;
  localparam int HUE_FIRST = DIV_STEPS - HUE_W;
  localparam int SAT_FIRST = DIV_STEPS - COLOR_BITS;

  localparam logic [HNUM_W-1:0] DEG_PER_SECTOR = HNUM_W'(60);

  typedef enum logic [1:0] {
    SECT_RED   = 2'd0,
    SECT_GREEN = 2'd1,
    SECT_BLUE  = 2'd2
  } sector_e;

  typedef struct packed {
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]      hue;
    logic [COLOR_BITS-1:0] saturation;
    logic [COLOR_BITS-1:0] value;
  } hsv_t;

  // After the max/min compare.
  typedef struct packed {
    logic [COLOR_BITS-1:0]        max_c;
    logic [COLOR_BITS-1:0]        min_c;
    sector_e                      sector;
    logic signed [COLOR_BITS:0]   diff;
  } rank_t;

  // After the sector factor.
  typedef struct packed {
    logic [COLOR_BITS-1:0] max_c;
    logic [COLOR_BITS-1:0] delta;
    logic [FACTOR_W-1:0]   factor;
  } factor_t;

  // Running state of the two restoring dividers.
  typedef struct packed {
    logic [COLOR_BITS-1:0] hue_rem;
    logic [HUE_W-1:0]      hue_acc;
    logic [COLOR_BITS-1:0] hue_den;
    logic [COLOR_BITS-1:0] sat_rem;
    logic [COLOR_BITS-1:0] sat_acc;
    logic [COLOR_BITS-1:0] sat_den;
    logic [COLOR_BITS-1:0] value;
  } div_t;

endpackage

// ===== sv/rgbhsv_prep.sv =====
// Front stages: max/min ranking, sector factor, and divider numerators.
module rgbhsv_prep (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rgbhsv_pkg::pixel_t    in_pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rgbhsv_pkg::div_t      out_div_o
);
  import rgbhsv_pkg::*;

  logic    rank_valid_q, fact_valid_q, num_valid_q;
  logic    rank_stall, fact_stall, num_stall;
  rank_t   rank_d, rank_q;
  factor_t fact_d, fact_q;
  div_t    num_d, num_q;

  logic [FACTOR_W-1:0] delta_ext;
  logic [FACTOR_W-1:0] scaled_delta;
  logic [HNUM_W-1:0]   hue_num;
  logic [SNUM_W-1:0]   sat_num;

  assign num_stall  = num_valid_q & out_stall_i;
  assign fact_stall = fact_valid_q & num_stall;
  assign rank_stall = rank_valid_q & fact_stall;
  assign in_stall_o = rank_stall;

  // Rank: red wins ties over green, green over blue.
  always_comb begin
    rank_d = '0;
    if (in_pixel_i.red >= in_pixel_i.green && in_pixel_i.red >= in_pixel_i.blue) begin
      rank_d.sector = SECT_RED;
      rank_d.max_c  = in_pixel_i.red;
      rank_d.diff   = $signed({1'b0, in_pixel_i.green}) - $signed({1'b0, in_pixel_i.blue});
    end else if (in_pixel_i.green >= in_pixel_i.blue) begin
      rank_d.sector = SECT_GREEN;
      rank_d.max_c  = in_pixel_i.green;
      rank_d.diff   = $signed({1'b0, in_pixel_i.blue}) - $signed({1'b0, in_pixel_i.red});
    end else begin
      rank_d.sector = SECT_BLUE;
      rank_d.max_c  = in_pixel_i.blue;
      rank_d.diff   = $signed({1'b0, in_pixel_i.red}) - $signed({1'b0, in_pixel_i.green});
    end
    rank_d.min_c = in_pixel_i.red;
    if (in_pixel_i.green < rank_d.min_c) rank_d.min_c = in_pixel_i.green;
    if (in_pixel_i.blue < rank_d.min_c) rank_d.min_c = in_pixel_i.blue;
  end

  // Factor = sector offset * delta + diff; never negative.
  always_comb begin
    fact_d       = '0;
    fact_d.max_c = rank_q.max_c;
    fact_d.delta = rank_q.max_c - rank_q.min_c;
    delta_ext    = FACTOR_W'(fact_d.delta);
    case (rank_q.sector)
      SECT_RED:   scaled_delta = rank_q.diff[COLOR_BITS] ?
                                 (delta_ext << 2) + (delta_ext << 1) : '0;
      SECT_GREEN: scaled_delta = delta_ext << 1;
      SECT_BLUE:  scaled_delta = delta_ext << 2;
      default:    scaled_delta = '0;
    endcase
    fact_d.factor = scaled_delta + {{2{rank_q.diff[COLOR_BITS]}}, rank_q.diff};
  end

  // Numerators; a zero divisor becomes one over a zero numerator.
  always_comb begin
    num_d       = '0;
    num_d.value = fact_q.max_c;
    hue_num     = ((HNUM_W'(fact_q.factor) * DEG_PER_SECTOR) << HUE_FRAC_BITS);
    sat_num     = {fact_q.delta, {COLOR_BITS{1'b0}}} - SNUM_W'(fact_q.delta);
    if (fact_q.delta == '0) begin
      hue_num       = '0;
      num_d.hue_den = COLOR_BITS'(1);
    end else begin
      num_d.hue_den = fact_q.delta;
    end
    if (fact_q.max_c == '0) begin
      sat_num       = '0;
      num_d.sat_den = COLOR_BITS'(1);
    end else begin
      num_d.sat_den = fact_q.max_c;
    end
    num_d.hue_rem = hue_num[HNUM_W-1:HUE_W];
    num_d.hue_acc = hue_num[HUE_W-1:0];
    num_d.sat_rem = sat_num[SNUM_W-1:COLOR_BITS];
    num_d.sat_acc = sat_num[COLOR_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_valid_q <= 1'b0;
      fact_valid_q <= 1'b0;
      num_valid_q  <= 1'b0;
    end else begin
      if (!rank_stall) rank_valid_q <= in_valid_i;
      if (!fact_stall) fact_valid_q <= rank_valid_q;
      if (!num_stall)  num_valid_q  <= fact_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!rank_stall && in_valid_i) rank_q <= rank_d;
    if (!fact_stall && rank_valid_q) fact_q <= fact_d;
    if (!num_stall && fact_valid_q) num_q <= num_d;
  end

  assign out_valid_o = num_valid_q;
  assign out_div_o   = num_q;

endmodule

// ===== sv/rgbhsv_div_stage.sv =====
// One registered restoring-division step for the hue and saturation dividers.
module rgbhsv_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              do_hue_i,
  input  logic              do_sat_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rgbhsv_pkg::div_t  in_div_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rgbhsv_pkg::div_t  out_div_o
);
  import rgbhsv_pkg::*;

  logic                  valid_q;
  logic                  stall;
  div_t                  div_d, div_q;
  logic [COLOR_BITS:0]   hue_trial, hue_sub;
  logic [COLOR_BITS:0]   sat_trial, sat_sub;
  logic                  hue_bit, sat_bit;

  assign stall      = valid_q & out_stall_i;
  assign in_stall_o = stall;

  always_comb begin
    div_d     = in_div_i;
    hue_trial = {in_div_i.hue_rem, in_div_i.hue_acc[HUE_W-1]};
    hue_sub   = hue_trial - {1'b0, in_div_i.hue_den};
    hue_bit   = (hue_trial >= {1'b0, in_div_i.hue_den});
    sat_trial = {in_div_i.sat_rem, in_div_i.sat_acc[COLOR_BITS-1]};
    sat_sub   = sat_trial - {1'b0, in_div_i.sat_den};
    sat_bit   = (sat_trial >= {1'b0, in_div_i.sat_den});
    if (do_hue_i) begin
      div_d.hue_rem = hue_bit ? hue_sub[COLOR_BITS-1:0] : hue_trial[COLOR_BITS-1:0];
      div_d.hue_acc = {in_div_i.hue_acc[HUE_W-2:0], hue_bit};
    end
    if (do_sat_i) begin
      div_d.sat_rem = sat_bit ? sat_sub[COLOR_BITS-1:0] : sat_trial[COLOR_BITS-1:0];
      div_d.sat_acc = {in_div_i.sat_acc[COLOR_BITS-2:0], sat_bit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && in_valid_i) div_q <= div_d;
  end

  assign out_valid_o = valid_q;
  assign out_div_o   = div_q;

endmodule

// ===== sv/rgb_to_hsv_converter_top.sv =====
// RGB to HSV converter: three front stages and a chain of divider stages.
//
// Input channel: in_valid_i / in_stall_o with one RGB pixel per beat on
// in_pixel_i. Output channel: out_valid_o / out_stall_i with hue (1/64 degree
// units), saturation and value on out_hsv_o. A beat moves on a rising edge
// with valid high and stall low.
// The path runs through max/min rank, sector factor, numerator setup, then
// one quotient bit per stage of the hue divider, whose 15-bit quotient sets
// the depth. The saturation divider runs alongside in the last COLOR_BITS
// stages.
// Throughput is one pixel per cycle while the receiver does not stall. Every stage has its own valid bit and
// takes a new beat whenever it is empty or its successor moves, so bubbles
// fill in under stall. When the receiver stalls, the last stage holds its
// result and stall backs up stage by stage; nothing is dropped or repeated.
// Reset clears all valid bits; the block holds no state between pixels.
module rgb_to_hsv_converter_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rgbhsv_pkg::pixel_t  in_pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rgbhsv_pkg::hsv_t    out_hsv_o
);
  import rgbhsv_pkg::*;

  logic [DIV_STEPS:0] vld;
  logic [DIV_STEPS:0] stl;
  div_t               dat [DIV_STEPS+1];

  rgbhsv_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_pixel_i  (in_pixel_i),
    .out_valid_o (vld[0]),
    .out_stall_i (stl[0]),
    .out_div_o   (dat[0])
  );

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    rgbhsv_div_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .do_hue_i    ((i >= HUE_FIRST) ? 1'b1 : 1'b0),
      .do_sat_i    ((i >= SAT_FIRST) ? 1'b1 : 1'b0),
      .in_valid_i  (vld[i]),
      .in_stall_o  (stl[i]),
      .in_div_i    (dat[i]),
      .out_valid_o (vld[i+1]),
      .out_stall_i (stl[i+1]),
      .out_div_o   (dat[i+1])
    );
  end

  assign stl[DIV_STEPS] = out_stall_i;

  assign out_valid_o          = vld[DIV_STEPS];
  assign out_hsv_o.hue        = dat[DIV_STEPS].hue_acc;
  assign out_hsv_o.saturation = dat[DIV_STEPS].sat_acc;
  assign out_hsv_o.value      = dat[DIV_STEPS].value;

endmodule

// ===== tb/rgb_to_hsv_checker.sv =====
// Checker for the RGB to HSV converter: predicts each pixel's HSV beat and compares.
`timescale 1ns / 1ps

module rgb_to_hsv_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  rgbhsv_pkg::pixel_t in_pixel_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  rgbhsv_pkg::hsv_t   out_hsv_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  import rgbhsv_pkg::*;

  localparam int COLOR_MAX = (1 << COLOR_BITS) - 1;
  localparam int HUE_UNIT  = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL  = 360 << HUE_FRAC_BITS;

  hsv_t expected_hsv_q[$];
  int   mismatches = 0;

  function automatic hsv_t predict_hsv(pixel_t px);
    int      r, g, b, mx, mn, delta, hue;
    sector_e sect;
    hsv_t    res;
    r = px.red;
    g = px.green;
    b = px.blue;
    // Strict compares keep red ahead of green and green ahead of blue on ties.
    mx   = r;
    sect = SECT_RED;
    if (g > mx) begin
      mx   = g;
      sect = SECT_GREEN;
    end
    if (b > mx) begin
      mx   = b;
      sect = SECT_BLUE;
    end
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    hue   = 0;
    if (delta != 0) begin
      case (sect)
        SECT_RED: begin
          // Negative angles wrap by a full turn before truncation.
          if (g >= b) hue = (HUE_UNIT * (g - b)) / delta;
          else        hue = (HUE_FULL * delta - HUE_UNIT * (b - g)) / delta;
        end
        SECT_GREEN: hue = (HUE_UNIT * (2 * delta + b - r)) / delta;
        SECT_BLUE:  hue = (HUE_UNIT * (4 * delta + r - g)) / delta;
        default:    hue = 0;
      endcase
    end
    res.hue        = hue[HUE_W-1:0];
    res.saturation = (mx == 0) ? '0 : COLOR_BITS'((delta * COLOR_MAX) / mx);
    res.value      = COLOR_BITS'(mx);
    return res;
  endfunction

  always @(posedge clk_i) begin
    hsv_t want;
    if (rst_ni) begin
      // Compare before pushing: a beat leaving now never belongs to one entering now.
      if (out_valid_i && !out_stall_i) begin
        if (expected_hsv_q.size() == 0) begin
          $error("output beat with no pixel pending: hue %0d sat %0d value %0d",
                 out_hsv_i.hue, out_hsv_i.saturation, out_hsv_i.value);
          mismatches++;
        end else begin
          want = expected_hsv_q.pop_front();
          if (out_hsv_i.hue !== want.hue) begin
            $error("hue mismatch: expected %0d, actual %0d", want.hue, out_hsv_i.hue);
            mismatches++;
          end
          if (out_hsv_i.saturation !== want.saturation) begin
            $error("saturation mismatch: expected %0d, actual %0d",
                   want.saturation, out_hsv_i.saturation);
            mismatches++;
          end
          if (out_hsv_i.value !== want.value) begin
            $error("value mismatch: expected %0d, actual %0d", want.value, out_hsv_i.value);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) expected_hsv_q.push_back(predict_hsv(in_pixel_i));
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_hsv_q.size();
  end

endmodule

// ===== tb/tb_rgb_to_hsv_converter_top.sv =====
// Testbench top for the RGB to HSV converter: pixel stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_top;
  import rgbhsv_pkg::*;

  localparam int NUM_RANDOM  = 2000;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 3 + DIV_STEPS + 10;
  localparam int HOLD_START  = 600;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_e;

  logic   clk       = 1'b0;
  logic   rst_n     = 1'b0;
  logic   in_valid  = 1'b0;
  pixel_t in_pixel  = '0;
  logic   out_stall = 1'b0;
  logic   in_stall;
  logic   out_valid;
  hsv_t   out_hsv;
  int     fail_count;
  int     pending;
  int     burst_left = 0;
  int     idle_cycles = 0;

  always #1 clk = ~clk;

  rgb_to_hsv_converter_top u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_pixel_i (in_pixel),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_hsv_o  (out_hsv)
  );

  rgb_to_hsv_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_pixel_i  (in_pixel),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_hsv_i   (out_hsv),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Offer one pixel, opening a new burst after a random gap when the last one ran out.
  task automatic send_pixel(input pixel_t px);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 10);
      burst_left = $urandom_range(1, 40);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_pixel <= px;
    do @(posedge clk); while (in_stall);
  endtask

  initial begin
    logic [3*COLOR_BITS-1:0] directed_px [22] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'hFF0000, 24'h00FF00, 24'h0000FF,
      24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hFF0100, 24'h010000,
      24'h000100, 24'h000001, 24'hFFFEFF, 24'h0AC864, 24'hC80A64, 24'h640AC8,
      24'h01FF00, 24'h00FF01, 24'h7F807F, 24'h010101
    };
    pixel_t px;
    logic [COLOR_BITS-1:0] v, w;
    int sel;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_px[i]) send_pixel(directed_px[i]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      v = COLOR_BITS'($urandom_range(0, 255));
      w = COLOR_BITS'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: px = (3*COLOR_BITS)'($urandom);
        5: px = {v, v, v};
        6: begin
          // Two channels tie, the third is free.
          sel = $urandom_range(0, 2);
          if (sel == 0)      px = {v, v, w};
          else if (sel == 1) px = {v, w, v};
          else               px = {w, v, v};
        end
        7: begin
          px = (3*COLOR_BITS)'($urandom);
          if ($urandom_range(0, 1)) px.red   = $urandom_range(0, 1) ? '1 : '0;
          if ($urandom_range(0, 1)) px.green = $urandom_range(0, 1) ? '1 : '0;
          if ($urandom_range(0, 1)) px.blue  = $urandom_range(0, 1) ? '1 : '0;
        end
        8: px = {8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3))};
        default: begin
          px = (3*COLOR_BITS)'($urandom);
          sel = $urandom_range(0, 2);
          if (sel == 0)      px.red   = '1;
          else if (sel == 1) px.green = '1;
          else               px.blue  = '1;
        end
      endcase
      send_pixel(px);
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_rgb_to_hsv_converter_top: done, clean");
    end else begin
      $display("tb_rgb_to_hsv_converter_top: done, errors");
    end
    $finish;
  end

  // Receiver: stall pattern redrawn at random at regular intervals, with one long hold-off to back up the pipe.
  initial begin
    stall_mode_e mode = STALL_NONE;
    int cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = stall_mode_e'($urandom_range(0, 3));
      if (cyc >= HOLD_START && cyc < HOLD_START + HOLD_CYCLES) begin
        out_stall <= 1'b1;
      end else begin
        case (mode)
          STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
          STALL_TOGGLE: out_stall <= cyc[0];
          default:      out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Watchdog: end the run when no beat moves on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_rgb_to_hsv_converter_top: done, errors");
        $finish;
      end
    end
  end

endmodule
